/* design/mahs_pkg.sv */
`default_nettype none
package mahs_pkg;

  // field widths fixed by the item format
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned SPEED_W  = 23;

  // configuration register indexes
  localparam logic CFG_START_SPEED = 1'b0;
  localparam logic CFG_FINAL_SPEED = 1'b1;

  // configuration reset values
  localparam logic [SPEED_W-1:0] START_SPEED_RST = 23'd15000;
  localparam logic [SPEED_W-1:0] FINAL_SPEED_RST = 23'd1000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_POLL   = 2'd0,
    FUNC_HOME   = 2'd1,
    FUNC_ROTATE = 2'd2,
    FUNC_STOP   = 2'd3
  } func_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAIT     = 2'd0,
    MODE_ROTATING = 2'd1,
    MODE_STOPPING = 2'd2,
    MODE_HOMING   = 2'd3
  } mode_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_WAIT = 3'd0,
    PH_RISE = 3'd1,
    PH_ON   = 3'd2,
    PH_FALL = 3'd3,
    PH_ZERO = 3'd4
  } phase_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE       = 3'd0,
    ACT_STOP       = 3'd1,
    ACT_ESTOP      = 3'd2,
    ACT_RUN        = 3'd3,
    ACT_RESET_ZERO = 3'd4,
    ACT_FINISHED   = 3'd5,
    ACT_HOME_ERR   = 3'd6,
    ACT_START_MOVE = 3'd7
  } action_t;

  // one input item as held in the input register
  typedef struct packed {
    func_t func;
    logic  is_moving;
    logic  home_sensor;
    logic  stop_hard;
  } item_t;

  // supervisor control state
  typedef struct packed {
    mode_t  mode;
    phase_t phase;
  } ctl_t;

endpackage
`default_nettype wire

/* design/mahs_if.sv */
`default_nettype none
// input item channel
interface mahs_item_if;
  logic                        valid;
  logic                        ready;
  logic [mahs_pkg::FUNC_W-1:0] func;
  logic                        is_moving;
  logic                        home_sensor;
  logic                        stop_hard;

  modport source (output valid, func, is_moving, home_sensor, stop_hard, input ready);
  modport sink   (input valid, func, is_moving, home_sensor, stop_hard, output ready);
endinterface

// result item channel
interface mahs_result_if #(
  parameter int unsigned VEL_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [mahs_pkg::ACTION_W-1:0] action;
  logic signed [VEL_BITS-1:0]    run_velocity;
  logic [mahs_pkg::MODE_W-1:0]   axis_mode;
  logic [mahs_pkg::PHASE_W-1:0]  home_phase;

  modport source (output valid, action, run_velocity, axis_mode, home_phase, input ready);
  modport sink   (input valid, action, run_velocity, axis_mode, home_phase, output ready);
endinterface
`default_nettype wire

/* design/mahs_step.sv */
`default_nettype none
module mahs_step #(
  parameter int unsigned VEL_BITS = 24
) (
  input  mahs_pkg::item_t                    item,
  input  mahs_pkg::ctl_t                     ctl_q,
  input  logic signed [VEL_BITS-1:0]         last_q,
  input  logic [mahs_pkg::SPEED_W-1:0]       start_speed,
  input  logic [mahs_pkg::SPEED_W-1:0]       final_speed,
  output mahs_pkg::ctl_t                     ctl_d,
  output logic signed [VEL_BITS-1:0]         last_d,
  output mahs_pkg::action_t                  action,
  output logic signed [VEL_BITS-1:0]         run_vel
);

  localparam logic [VEL_BITS-1:0] VEL_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};

  logic [VEL_BITS-1:0]        sat_start;
  logic [VEL_BITS-1:0]        sat_final;
  logic [VEL_BITS-1:0]        last_adj;
  logic signed [VEL_BITS-1:0] half_tz;
  logic signed [VEL_BITS-1:0] rev_vel;
  logic signed [VEL_BITS-1:0] new_vel;
  logic [VEL_BITS-1:0]        new_mag;

  // register speeds clipped to the largest positive velocity
  assign sat_start = (33'(start_speed) > 33'(VEL_MAX)) ? VEL_MAX
                                                       : VEL_BITS'(start_speed);
  assign sat_final = (33'(final_speed) > 33'(VEL_MAX)) ? VEL_MAX
                                                       : VEL_BITS'(final_speed);

  // reverse at half speed (halving truncated toward zero), or final speed when the home sensor is set
  assign last_adj = last_q + VEL_BITS'(last_q[VEL_BITS-1]);
  assign half_tz  = $signed(last_adj) >>> 1;
  assign rev_vel  = -half_tz;
  assign new_vel  = item.home_sensor ? $signed(sat_final) : rev_vel;
  assign new_mag  = new_vel[VEL_BITS-1] ? VEL_BITS'(-new_vel) : VEL_BITS'(new_vel);

  // next state and action for one item
  always_comb begin
    ctl_d   = ctl_q;
    last_d  = last_q;
    action  = mahs_pkg::ACT_NONE;
    run_vel = '0;
    case (item.func)
      mahs_pkg::FUNC_POLL: begin
        case (ctl_q.mode)
          mahs_pkg::MODE_ROTATING: begin
            if (!item.is_moving) ctl_d.mode = mahs_pkg::MODE_STOPPING;
          end
          mahs_pkg::MODE_STOPPING: begin
            if (!item.is_moving) begin
              ctl_d.mode = mahs_pkg::MODE_WAIT;
              action     = mahs_pkg::ACT_FINISHED;
            end
          end
          mahs_pkg::MODE_HOMING: begin
            case (ctl_q.phase)
              mahs_pkg::PH_WAIT: begin
                if (item.is_moving) begin
                  action = mahs_pkg::ACT_STOP;
                end else begin
                  run_vel     = $signed(sat_start);
                  last_d      = $signed(sat_start);
                  ctl_d.phase = mahs_pkg::PH_RISE;
                  action      = mahs_pkg::ACT_RUN;
                end
              end
              mahs_pkg::PH_RISE: begin
                if (item.home_sensor) begin
                  ctl_d.phase = mahs_pkg::PH_ON;
                  action      = mahs_pkg::ACT_STOP;
                end
              end
              mahs_pkg::PH_ON: begin
                if (item.is_moving) begin
                  action = mahs_pkg::ACT_STOP;
                end else if (33'(new_mag) < 33'(final_speed)) begin
                  // search speed too low
                  ctl_d.mode  = mahs_pkg::MODE_STOPPING;
                  ctl_d.phase = mahs_pkg::PH_WAIT;
                  action      = mahs_pkg::ACT_HOME_ERR;
                end else begin
                  run_vel     = new_vel;
                  last_d      = new_vel;
                  ctl_d.phase = item.home_sensor ? mahs_pkg::PH_FALL : mahs_pkg::PH_RISE;
                  action      = mahs_pkg::ACT_RUN;
                end
              end
              mahs_pkg::PH_FALL: begin
                if (!item.home_sensor) begin
                  ctl_d.phase = mahs_pkg::PH_ZERO;
                  action      = mahs_pkg::ACT_ESTOP;
                end
              end
              mahs_pkg::PH_ZERO: begin
                if (!item.is_moving) begin
                  ctl_d.mode  = mahs_pkg::MODE_WAIT;
                  ctl_d.phase = mahs_pkg::PH_WAIT;
                  action      = mahs_pkg::ACT_RESET_ZERO;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      mahs_pkg::FUNC_HOME: begin
        ctl_d.phase = mahs_pkg::PH_WAIT;
        ctl_d.mode  = mahs_pkg::MODE_HOMING;
      end
      mahs_pkg::FUNC_ROTATE: begin
        ctl_d.mode = mahs_pkg::MODE_ROTATING;
        action     = mahs_pkg::ACT_START_MOVE;
      end
      default: begin
        ctl_d.mode = mahs_pkg::MODE_STOPPING;
        action     = item.stop_hard ? mahs_pkg::ACT_ESTOP : mahs_pkg::ACT_STOP;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/motor_axis_homing_supervisor.sv */
`default_nettype none
// an input item passes the input register and then the result register before its result is offered
// throughput: one item per cycle; input register, step logic, result register
// a stall on the result side holds both stages, a new item enters as soon as one moves
// reset (rst_n low, synchronous): mode wait, phase wait, last speed zero,
// start speed 15000, final speed 1000, both stages empty
module motor_axis_homing_supervisor #(
  parameter int unsigned VEL_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mahs_item_if.sink                          in_item,
  mahs_result_if.source                      out_result,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [mahs_pkg::SPEED_W-1:0]  cfg_wdata
);

  logic [mahs_pkg::SPEED_W-1:0] start_speed_r;
  logic [mahs_pkg::SPEED_W-1:0] final_speed_r;

  logic                         s1_valid_r;
  mahs_pkg::item_t              s1_item_r;
  mahs_pkg::ctl_t               ctl_r;
  logic signed [VEL_BITS-1:0]   last_speed_r;

  logic                         out_valid_r;
  mahs_pkg::action_t            action_r;
  logic signed [VEL_BITS-1:0]   vel_r;
  mahs_pkg::ctl_t               out_ctl_r;

  mahs_pkg::ctl_t               ctl_nxt;
  logic signed [VEL_BITS-1:0]   last_speed_nxt;
  mahs_pkg::action_t            action_nxt;
  logic signed [VEL_BITS-1:0]   vel_nxt;

  logic advance;
  logic s1_ready;

  // handshake between stages
  assign advance        = !out_valid_r || out_result.ready;
  assign s1_ready       = !s1_valid_r || advance;
  assign in_item.ready  = s1_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_speed_r <= mahs_pkg::START_SPEED_RST;
      final_speed_r <= mahs_pkg::FINAL_SPEED_RST;
    end else if (cfg_we) begin
      if (cfg_index == mahs_pkg::CFG_START_SPEED) start_speed_r <= cfg_wdata;
      if (cfg_index == mahs_pkg::CFG_FINAL_SPEED) final_speed_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_item.valid) begin
      s1_item_r.func        <= mahs_pkg::func_t'(in_item.func);
      s1_item_r.is_moving   <= in_item.is_moving;
      s1_item_r.home_sensor <= in_item.home_sensor;
      s1_item_r.stop_hard   <= in_item.stop_hard;
    end
  end

  // step logic
  mahs_step #(
    .VEL_BITS (VEL_BITS)
  ) u_step (
    .item        (s1_item_r),
    .ctl_q       (ctl_r),
    .last_q      (last_speed_r),
    .start_speed (start_speed_r),
    .final_speed (final_speed_r),
    .ctl_d       (ctl_nxt),
    .last_d      (last_speed_nxt),
    .action      (action_nxt),
    .run_vel     (vel_nxt)
  );

  // supervisor state, updated as an item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode   <= mahs_pkg::MODE_WAIT;
      ctl_r.phase  <= mahs_pkg::PH_WAIT;
      last_speed_r <= '0;
    end else if (s1_valid_r && advance) begin
      ctl_r        <= ctl_nxt;
      last_speed_r <= last_speed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      action_r  <= action_nxt;
      vel_r     <= vel_nxt;
      out_ctl_r <= ctl_nxt;
    end
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.action       = action_r;
  assign out_result.run_velocity = vel_r;
  assign out_result.axis_mode    = out_ctl_r.mode;
  assign out_result.home_phase   = out_ctl_r.phase;

endmodule
`default_nettype wire
